// ----- design/assert_macros.svh -----
// Assertion helpers used by the histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LH_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define LH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LH_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define LH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/lhist_pkg.sv -----
package lhist_pkg;

  localparam int NUM_BUCKETS_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int LAT_W   = 32;
  localparam int PCT_W   = 10;
  localparam int TOTAL_W = 37;
  localparam int TGT_W   = TOTAL_W + PCT_W;

  localparam logic [PCT_W-1:0]   PERMILLE_MAX = PCT_W'(1000);
  localparam logic [TOTAL_W-1:0] TOTAL_CAP    = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic rec;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- design/log2_latency_histogram.sv -----
// channel  ports                                   request taken when
// -------  --------------------------------------  ------------------------
// input    in_action in_latency_us                 start && !busy
//          in_percentile_permille
// result   out_percentile_us out_max_latency_us    out_valid (one cycle)
//          out_sample_total
//
// Record: result strobed in the cycle after it is taken; busy stays low.
// Query: the bucket ring rotates once through the head cell while busy is
// high, result strobed as busy falls; no new request is taken meanwhile.
// Synchronous reset clears all bucket counts, the maximum and the total.
// The result is shown for one cycle only; the receiver cannot stall it.
`include "assert_macros.svh"

module log2_latency_histogram #(
  parameter int NUM_BUCKETS = lhist_pkg::NUM_BUCKETS_DEF,
  parameter int COUNT_WIDTH = lhist_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [lhist_pkg::LAT_W-1:0]   in_latency_us,
  input  logic [lhist_pkg::PCT_W-1:0]   in_percentile_permille,
  output logic                          out_valid,
  output logic [lhist_pkg::LAT_W-1:0]   out_percentile_us,
  output logic [lhist_pkg::LAT_W-1:0]   out_max_latency_us,
  output logic [lhist_pkg::TOTAL_W-1:0] out_sample_total
);
  import lhist_pkg::*;

  localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CNT_W = $clog2(NUM_BUCKETS + 1);
  localparam int SUM_W = ((COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_BUCKETS);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  function automatic logic [LAT_W-1:0] bound_of(input logic [IDX_W-1:0] idx);
    logic [LAT_W-1:0] b;
    if (32'(idx) >= LAT_W) begin
      b = '1;
    end else begin
      b = LAT_W'(1) << idx;
    end
    return b;
  endfunction

  state_t               state_r;
  logic                 out_valid_r;
  logic [LAT_W-1:0]     pct_r;
  logic [LAT_W-1:0]     max_r;
  logic [TOTAL_W-1:0]   total_r;
  logic [TOTAL_W-1:0]   running_r;
  logic [TGT_W-1:0]     target_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 found_r;
  logic [IDX_W-1:0]     idx_r;

  logic                 accept;
  logic                 rec_go;
  cell_ctrl_t           ctrl;
  logic                 lat_zero;
  logic [LAT_W-1:0]     lat_m1;
  logic [NUM_BUCKETS-1:0] le;
  logic [NUM_BUCKETS-1:0] hit;
  logic [NUM_BUCKETS-1:0] inc;
  logic [COUNT_WIDTH-1:0] cnt_out [NUM_BUCKETS];

  logic [PCT_W-1:0]     p_cap;
  logic [SUM_W-1:0]     run_sum;
  logic [TOTAL_W-1:0]   running_nxt;
  logic [TGT_W-1:0]     run_x1000;
  logic                 reach;
  logic                 found_nxt;
  logic [IDX_W-1:0]     idx_nxt;
  logic [IDX_W-1:0]     idx_prev;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign rec_go = accept && !in_action;

  assign ctrl.rec   = rec_go;
  assign ctrl.shift = (state_r == ST_SCAN) && (cnt_r < SCAN_END);

  assign lat_zero = (in_latency_us == '0);
  assign lat_m1   = in_latency_us - LAT_W'(1);

  for (genvar i = 0; i < NUM_BUCKETS; i++) begin : g_cell
    localparam int NXT = (i + 1) % NUM_BUCKETS;
    logic le_prev;
    if (i == 0) begin : g_first
      assign le_prev = 1'b0;
    end else begin : g_rest
      assign le_prev = le[i-1];
    end
    lhist_cell #(
      .IDX         (i),
      .LAST        (i == NUM_BUCKETS - 1),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .lat_zero (lat_zero),
      .lat_m1   (lat_m1),
      .le_prev  (le_prev),
      .le       (le[i]),
      .hit      (hit[i]),
      .inc      (inc[i]),
      .cnt_in   (cnt_out[NXT]),
      .cnt_out  (cnt_out[i])
    );
  end

  assign p_cap = (in_percentile_permille > PERMILLE_MAX) ? PERMILLE_MAX
                                                         : in_percentile_permille;

  assign run_sum     = SUM_W'(running_r) + SUM_W'(cnt_out[0]);
  assign running_nxt = (run_sum > SUM_W'(TOTAL_CAP)) ? TOTAL_CAP : run_sum[TOTAL_W-1:0];

  // running >= ceil(total*p/1000)  <=>  1000*running >= total*p
  assign run_x1000 = (TGT_W'(running_r) << 10) - (TGT_W'(running_r) << 4)
                   - (TGT_W'(running_r) << 3);
  assign idx_prev  = IDX_W'(cnt_r - CNT_W'(1));
  assign reach     = (cnt_r != '0) && !found_r && (run_x1000 >= target_r);
  assign found_nxt = found_r | reach;
  assign idx_nxt   = reach ? idx_prev : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      max_r       <= '0;
      total_r     <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (rec_go) begin
            out_valid_r <= 1'b1;
            pct_r       <= '0;
            if (in_latency_us > max_r) begin
              max_r <= in_latency_us;
            end
            if (|inc && (total_r != TOTAL_CAP)) begin
              total_r <= total_r + TOTAL_W'(1);
            end
          end else if (accept) begin
            state_r   <= ST_SCAN;
            running_r <= '0;
            target_r  <= TGT_W'(total_r) * TGT_W'(p_cap);
            cnt_r     <= '0;
            found_r   <= 1'b0;
            idx_r     <= LAST_IDX;
          end
        end
        ST_SCAN: begin
          found_r <= found_nxt;
          idx_r   <= idx_nxt;
          if (cnt_r < SCAN_END) begin
            running_r <= running_nxt;
            cnt_r     <= cnt_r + CNT_W'(1);
          end else begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            pct_r       <= (total_r == '0) ? '0 : bound_of(idx_nxt);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_percentile_us  = pct_r;
  assign out_max_latency_us = max_r;
  assign out_sample_total   = total_r;

  `LH_ASSERT_SAME(a_one_bucket, clk, rst_n, rec_go, $onehot(hit), "record hits not one bucket")
  `LH_ASSERT_NEXT(a_rec_result, clk, rst_n, rec_go, out_valid && !busy, "record result missing")
  `LH_ASSERT_NEXT(a_query_busy, clk, rst_n, accept && in_action, busy && !out_valid, "query not scanning")
  `LH_ASSERT_SAME(a_empty_zero, clk, rst_n, out_valid && (out_sample_total == '0), out_percentile_us == '0, "nonzero answer on empty histogram")
  `LH_ASSERT_NEXT(a_max_mono, clk, rst_n, 1'b1, max_r >= $past(max_r), "maximum decreased")

endmodule

// ----- design/lhist_cell.sv -----
module lhist_cell #(
  parameter int IDX         = 0,
  parameter bit LAST        = 1'b0,
  parameter int COUNT_WIDTH = lhist_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lhist_pkg::cell_ctrl_t       ctrl,
  input  logic                        lat_zero,
  input  logic [lhist_pkg::LAT_W-1:0] lat_m1,
  input  logic                        le_prev,
  output logic                        le,
  output logic                        hit,
  output logic                        inc,
  input  logic [COUNT_WIDTH-1:0]      cnt_in,
  output logic [COUNT_WIDTH-1:0]      cnt_out
);
  import lhist_pkg::*;

  logic [COUNT_WIDTH-1:0] cnt_r;

  // sample <= 2^IDX
  assign le  = lat_zero | ((lat_m1 >> IDX) == '0);
  assign hit = LAST ? !le_prev : (le & !le_prev);
  assign inc = hit & (cnt_r != {COUNT_WIDTH{1'b1}});

  assign cnt_out = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.shift) begin
      cnt_r <= cnt_in;
    end else if (ctrl.rec && inc) begin
      cnt_r <= cnt_r + COUNT_WIDTH'(1);
    end
  end

endmodule

// ----- verif/tb_log2_latency_histogram.sv -----
module tb_log2_latency_histogram;
  timeunit 1ns;
  timeprecision 1ps;

  import lhist_pkg::*;

  localparam bit ACT_RECORD = 1'b0;
  localparam bit ACT_QUERY  = 1'b1;
  localparam int BUCKETS = NUM_BUCKETS_DEF;
  localparam int CNT_W = COUNT_WIDTH_DEF;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 2 * (BUCKETS + 2);
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [LAT_W-1:0]   pct_us;
    logic [LAT_W-1:0]   max_us;
    logic [TOTAL_W-1:0] total;
  } hist_answer_t;

  class hist_tracker;
    logic [CNT_W-1:0] counts [BUCKETS];
    logic [LAT_W-1:0] max_seen;
    hist_answer_t     pending_answers [$];
    int mismatches;
    int checked;
    int samples;
    int queries;

    function new();
      foreach (counts[i]) counts[i] = '0;
      max_seen = '0;
      mismatches = 0;
      checked = 0;
      samples = 0;
      queries = 0;
    endfunction

    // Predict the answer for an accepted request and queue it.
    function void note_request(bit act, logic [LAT_W-1:0] lat, logic [PCT_W-1:0] pm);
      hist_answer_t a;
      int b;
      int hit;
      logic [63:0] upper;
      logic [63:0] sum;
      logic [63:0] p;
      logic [63:0] target;
      logic [63:0] running;
      a.pct_us = '0;
      if (act == ACT_RECORD) begin
        b = 0;
        upper = 64'd1;
        while (b + 1 < BUCKETS && 64'(lat) > upper) begin
          b++;
          upper = upper << 1;
        end
        if (counts[b] != '1) counts[b] = counts[b] + 1'b1;
        if (lat > max_seen) max_seen = lat;
        samples++;
      end else begin
        queries++;
      end
      sum = '0;
      foreach (counts[i]) begin
        sum = sum + 64'(counts[i]);
        if (sum > 64'(TOTAL_CAP)) sum = 64'(TOTAL_CAP);
      end
      if (act == ACT_QUERY && sum != 0) begin
        p = (pm > PERMILLE_MAX) ? 64'(PERMILLE_MAX) : 64'(pm);
        target = (sum * p + 64'd999) / 64'd1000;
        running = '0;
        hit = BUCKETS - 1;
        for (int i = 0; i < BUCKETS; i++) begin
          running = running + 64'(counts[i]);
          if (running > 64'(TOTAL_CAP)) running = 64'(TOTAL_CAP);
          if (running >= target) begin
            hit = i;
            break;
          end
        end
        a.pct_us = (hit >= LAT_W) ? '1 : LAT_W'(64'd1 << hit);
      end
      a.max_us = max_seen;
      a.total = sum[TOTAL_W-1:0];
      pending_answers.push_back(a);
    endfunction

    function void check_result(logic [LAT_W-1:0] pct_us, logic [LAT_W-1:0] max_us,
                               logic [TOTAL_W-1:0] total);
      hist_answer_t want;
      checked++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no pending request: pct=%0d max=%0d total=%0d",
                   $realtime, pct_us, max_us, total);
        return;
      end
      want = pending_answers.pop_front();
      if (pct_us !== want.pct_us || max_us !== want.max_us || total !== want.total) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: mismatch: expected pct=%0d max=%0d total=%0d",
                   $realtime, want.pct_us, want.max_us, want.total);
          $display("%0t:                got pct=%0d max=%0d total=%0d",
                   $realtime, pct_us, max_us, total);
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_action = ACT_RECORD;
  logic [LAT_W-1:0]   in_latency_us = '0;
  logic [PCT_W-1:0]   in_percentile_permille = '0;
  logic               out_valid;
  logic [LAT_W-1:0]   out_percentile_us;
  logic [LAT_W-1:0]   out_max_latency_us;
  logic [TOTAL_W-1:0] out_sample_total;

  hist_tracker tracker = new();
  int quiet_cycles = 0;

  log2_latency_histogram dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_action              (in_action),
    .in_latency_us          (in_latency_us),
    .in_percentile_permille (in_percentile_permille),
    .out_valid              (out_valid),
    .out_percentile_us      (out_percentile_us),
    .out_max_latency_us     (out_max_latency_us),
    .out_sample_total       (out_sample_total)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Monitor: results first, then the request taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1)
        tracker.check_result(out_percentile_us, out_max_latency_us, out_sample_total);
      if (start && busy === 1'b0)
        tracker.note_request(in_action, in_latency_us, in_percentile_permille);
      if (out_valid === 1'b1 || (start && busy === 1'b0)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("watchdog: no activity for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_request(bit act, logic [LAT_W-1:0] lat, logic [PCT_W-1:0] pm);
    start <= 1'b1;
    in_action <= act;
    in_latency_us <= lat;
    in_percentile_permille <= pm;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending until every predicted answer has been seen.
  task automatic wait_settled();
    start <= 1'b0;
    do @(negedge clk); while (tracker.pending_answers.size() != 0);
    @(posedge clk);
  endtask

  task automatic run_phase(int count, int gap_pct);
    int gap;
    bit act;
    logic [LAT_W-1:0] lat;
    logic [PCT_W-1:0] pm;
    int k;
    for (int n = 0; n < count; n++) begin
      gap = 0;
      while ($urandom_range(0, 99) < gap_pct) gap++;
      if (gap > 0) hold_off(gap);
      act = ($urandom_range(0, 99) < 30) ? ACT_QUERY : ACT_RECORD;
      k = $urandom_range(0, 31);
      case ($urandom_range(0, 3))
        0: lat = $urandom;
        1: lat = $urandom_range(0, 64);
        2: lat = (32'd1 << k) + $urandom_range(0, 2) - 1;
        default: lat = $urandom >> k;
      endcase
      case ($urandom_range(0, 9))
        0: pm = PCT_W'($urandom_range(1001, 1023));
        1: pm = PCT_W'($urandom);
        2: pm = ($urandom_range(0, 1) != 0) ? PCT_W'(0) : PERMILLE_MAX;
        default: pm = PCT_W'($urandom_range(0, 1000));
      endcase
      push_request(act, lat, pm);
      if ($urandom_range(0, 199) == 0) wait_settled();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // queries on an empty histogram
    push_request(ACT_QUERY, '0, '0);
    push_request(ACT_QUERY, '1, PERMILLE_MAX);
    push_request(ACT_QUERY, '0, '1);
    // bucket edges and extremes
    push_request(ACT_RECORD, 32'd0, '0);
    push_request(ACT_RECORD, 32'd1, '1);
    push_request(ACT_RECORD, 32'd2, '0);
    push_request(ACT_RECORD, 32'd3, '0);
    push_request(ACT_RECORD, 32'd4, '0);
    push_request(ACT_RECORD, 32'd5, '0);
    push_request(ACT_RECORD, 32'd1000, '0);
    push_request(ACT_RECORD, 32'h7FFF_FFFF, '0);
    push_request(ACT_RECORD, 32'h8000_0000, '0);
    push_request(ACT_RECORD, 32'h8000_0001, '0);
    push_request(ACT_RECORD, 32'hFFFF_FFFF, '0);
    // percentile edges, including values past 1000
    push_request(ACT_QUERY, 32'h5555_5555, PCT_W'(0));
    push_request(ACT_QUERY, 32'hAAAA_AAAA, PCT_W'(1));
    push_request(ACT_QUERY, '0, PCT_W'(500));
    push_request(ACT_QUERY, '0, PCT_W'(512));
    push_request(ACT_QUERY, '0, PCT_W'(999));
    push_request(ACT_QUERY, '0, PERMILLE_MAX);
    push_request(ACT_QUERY, '0, PCT_W'(1001));
    push_request(ACT_QUERY, '0, '1);
    wait_settled();

    run_phase(580, 10);
    wait_settled();
    run_phase(580, 78);
    wait_settled();
    run_phase(590, 0);

    wait_settled();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d samples and %0d percentile queries, %0d results checked",
             tracker.samples, tracker.queries, tracker.checked);
    $display("%0d mismatches, %0d answers still pending",
             tracker.mismatches, tracker.pending_answers.size());
    if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
